>>> rtl/lkvt_pkg.sv
`timescale 1ns / 1ps

package lkvt_pkg;

	typedef enum logic [1:0] {
		MODE_SET    = 2'd0,
		MODE_GET    = 2'd1,
		MODE_DELETE = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_COMPARE,
		ST_SHIFT_RD,
		ST_SHIFT_WR,
		ST_RESPOND
	} state_t;

	typedef struct packed {
		logic load_req;
		logic rd_en;
		logic rd_next;
		logic idx_inc;
		logic count_clear;
		logic count_inc;
		logic count_dec;
		logic wr_append;
		logic wr_update;
		logic wr_shift;
		logic res_load;
		logic res_found;
		logic res_full;
		logic res_take_value;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  idx_lt_count;
		logic  idx1_lt_count;
		logic  key_match;
		logic  table_full;
		logic  out_free;
	} status_t;

endpackage

>>> rtl/lkvt_dp.sv
`timescale 1ns / 1ps

module lkvt_dp
	import lkvt_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output status_t     status,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        out_stall,
	output logic        out_valid,
	output logic        found,
	output logic [31:0] read_value,
	output logic [4:0]  entry_count,
	output logic        full_error
);

	localparam int KW = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
	localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [KW-1:0] key_mem [ENTRIES];
	logic [VW-1:0] val_mem [ENTRIES];

	mode_t         req_mode_q;
	logic [KW-1:0] req_key_q;
	logic [VW-1:0] req_value_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] idx1;
	logic [CW-1:0] count_q;
	logic [KW-1:0] rd_key_q;
	logic [VW-1:0] rd_val_q;
	logic          res_found_q;
	logic          res_full_q;
	logic [VW-1:0] res_value_q;
	logic          out_valid_q;
	logic          found_q;
	logic          full_error_q;
	logic [31:0]   read_value_q;
	logic [4:0]    entry_count_q;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic          wr_en;
	logic [VW-1:0] wr_val;

	assign idx1    = idx_q + 1'b1;
	assign rd_addr = cmd.rd_next ? idx1[IW-1:0] : idx_q[IW-1:0];
	assign wr_addr = cmd.wr_append ? count_q[IW-1:0] : idx_q[IW-1:0];
	assign wr_en   = cmd.wr_append | cmd.wr_update | cmd.wr_shift;
	assign wr_val  = cmd.wr_shift ? rd_val_q : req_value_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_mode_q  <= mode_t'(mode);
			req_key_q   <= key[KW-1:0];
			req_value_q <= value[VW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_key_q <= key_mem[rd_addr];
			rd_val_q <= val_mem[rd_addr];
		end
		if (wr_en) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (cmd.wr_append) begin
			key_mem[wr_addr] <= req_key_q;
		end else if (cmd.wr_shift) begin
			key_mem[wr_addr] <= rd_key_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.load_req) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx1;
			end
			priority if (cmd.count_clear) begin
				count_q <= '0;
			end else if (cmd.count_inc) begin
				count_q <= count_q + 1'b1;
			end else if (cmd.count_dec) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_found_q <= cmd.res_found;
			res_full_q  <= cmd.res_full;
			res_value_q <= cmd.res_take_value ? rd_val_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			found_q       <= res_found_q;
			full_error_q  <= res_full_q;
			read_value_q  <= 32'(res_value_q);
			entry_count_q <= 5'(count_q);
		end
	end

	assign status.mode          = req_mode_q;
	assign status.idx_lt_count  = (idx_q < count_q);
	assign status.idx1_lt_count = (idx1 < count_q);
	assign status.key_match     = (rd_key_q == req_key_q);
	assign status.table_full    = (count_q == CW'(ENTRIES));
	assign status.out_free      = !out_valid_q || !out_stall;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign full_error  = full_error_q;
	assign read_value  = read_value_q;
	assign entry_count = entry_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ENTRIES))
		else $error("Entry count exceeds the table depth.");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_append |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("Append did not grow the entry count by one.");

	a_found_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found_q && full_error_q))
		else $error("A word reports both a hit and a full table.");

	a_value_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && read_value_q != '0) |-> found_q)
		else $error("Nonzero read value without a hit.");
`endif

endmodule

>>> rtl/lkvt_ctrl.sv
`timescale 1ns / 1ps

module lkvt_ctrl
	import lkvt_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  status_t status,
	output cmd_t    cmd
);

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (status.mode == MODE_CLEAR || !status.idx_lt_count) begin
					state_d = ST_RESPOND;
				end else begin
					state_d = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				if (!status.key_match) begin
					state_d = ST_SEARCH;
				end else if (status.mode == MODE_DELETE) begin
					state_d = ST_SHIFT_RD;
				end else begin
					state_d = ST_RESPOND;
				end
			end
			ST_SHIFT_RD: begin
				state_d = status.idx1_lt_count ? ST_SHIFT_WR : ST_RESPOND;
			end
			ST_SHIFT_WR: begin
				state_d = ST_SHIFT_RD;
			end
			ST_RESPOND: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_req = accept;
			end
			ST_SEARCH: begin
				if (status.mode == MODE_CLEAR) begin
					cmd.count_clear = 1'b1;
					cmd.res_load    = 1'b1;
				end else if (status.idx_lt_count) begin
					cmd.rd_en = 1'b1;
				end else begin
					cmd.res_load = 1'b1;
					if (status.mode == MODE_SET) begin
						if (status.table_full) begin
							cmd.res_full = 1'b1;
						end else begin
							cmd.wr_append = 1'b1;
							cmd.count_inc = 1'b1;
						end
					end
				end
			end
			ST_COMPARE: begin
				if (!status.key_match) begin
					cmd.idx_inc = 1'b1;
				end else if (status.mode == MODE_SET) begin
					cmd.wr_update = 1'b1;
					cmd.res_load  = 1'b1;
					cmd.res_found = 1'b1;
				end else if (status.mode == MODE_GET) begin
					cmd.res_load       = 1'b1;
					cmd.res_found      = 1'b1;
					cmd.res_take_value = 1'b1;
				end
			end
			ST_SHIFT_RD: begin
				if (status.idx1_lt_count) begin
					cmd.rd_en   = 1'b1;
					cmd.rd_next = 1'b1;
				end else begin
					cmd.count_dec = 1'b1;
					cmd.res_load  = 1'b1;
					cmd.res_found = 1'b1;
				end
			end
			ST_SHIFT_WR: begin
				cmd.wr_shift = 1'b1;
				cmd.idx_inc  = 1'b1;
			end
			ST_RESPOND: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

>>> rtl/linear_key_value_table_unit.sv
// Linear key/value table with room for ENTRIES entries, kept in insertion order.
// The input channel (in_valid, in_stall) takes one request word: mode, key, value.
// Mode set updates a matching key or appends it, get looks it up, delete removes
// it and moves later entries down, and clear empties the table.
// Each request gives exactly one result word on the output channel
// (out_valid, out_stall): found, read_value, entry_count and full_error.
// Requests are handled one at a time; in_stall is high from acceptance until the
// result has been loaded into the output register.
// The search reads one slot of the entry memory per ST_SEARCH and ST_COMPARE pair,
// because the read data is registered before the key compare.
// Clear goes from ST_SEARCH straight to ST_RESPOND; after a hit, delete moves each
// later entry with an ST_SHIFT_RD and an ST_SHIFT_WR step before ST_RESPOND.
// The output register holds a word while out_stall is high and the block may
// finish the next request meanwhile, waiting only to load its result.
// Reset empties the table and drops any pending word; entry memory is not cleared.
`timescale 1ns / 1ps

module linear_key_value_table_unit
	import lkvt_pkg::*;
#(
	parameter int ENTRIES     = 16,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] key,
	input  logic [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        found,
	output logic [31:0] read_value,
	output logic [4:0]  entry_count,
	output logic        full_error
);

	cmd_t    cmd;
	status_t status;

	lkvt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	lkvt_dp #(
		.ENTRIES     (ENTRIES),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.found       (found),
		.read_value  (read_value),
		.entry_count (entry_count),
		.full_error  (full_error)
	);

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import lkvt_pkg::*;

	localparam int TABLE_DEPTH = 16;
	localparam int POOL_SIZE   = 20;
	localparam int RANDOM_WORDS = 450;

	typedef struct {
		mode_t       op;
		logic [31:0] k;
		logic [31:0] v;
		bit          drain;
	} request_t;

	typedef struct packed {
		logic        found;
		logic [31:0] read_value;
		logic [4:0]  entry_count;
		logic        full_error;
	} table_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = MODE_SET;
	logic [31:0] key = '0;
	logic [31:0] value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        found;
	logic [31:0] read_value;
	logic [4:0]  entry_count;
	logic        full_error;

	request_t      request_q[$];
	table_result_t table_expected_q[$];
	request_t      next_request;
	table_result_t got_result;
	table_result_t want_result;

	logic [31:0] key_table [TABLE_DEPTH];
	logic [31:0] value_table [TABLE_DEPTH];
	int unsigned table_count = 0;

	int words_sent;
	int results_seen;
	int total_words;
	int errors = 0;
	int burst_left;
	int gap_left;
	int hold_left;
	int next_long_hold;
	int stall_style;
	int style_left;

	linear_key_value_table_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.read_value (read_value),
		.entry_count(entry_count),
		.full_error (full_error)
	);

	always #10 clk = ~clk;

	// Applies one request to the table copy and returns the result word it should give.
	function automatic table_result_t table_apply(mode_t op, logic [31:0] k, logic [31:0] v);
		table_result_t r;
		int slot;
		int i;
		r = '0;
		slot = TABLE_DEPTH;
		if (op == MODE_CLEAR) begin
			table_count = 0;
		end else begin
			for (i = 0; i < table_count; i++) begin
				if (slot == TABLE_DEPTH && key_table[i] == k) begin
					slot = i;
				end
			end
			case (op)
				MODE_SET: begin
					if (slot < TABLE_DEPTH) begin
						value_table[slot] = v;
						r.found = 1'b1;
					end else if (table_count < TABLE_DEPTH) begin
						key_table[table_count] = k;
						value_table[table_count] = v;
						table_count++;
					end else begin
						r.full_error = 1'b1;
					end
				end
				MODE_GET: begin
					if (slot < TABLE_DEPTH) begin
						r.read_value = value_table[slot];
						r.found = 1'b1;
					end
				end
				default: begin
					if (slot < TABLE_DEPTH) begin
						for (i = slot; i + 1 < table_count; i++) begin
							key_table[i] = key_table[i + 1];
							value_table[i] = value_table[i + 1];
						end
						table_count--;
						r.found = 1'b1;
					end
				end
			endcase
		end
		r.entry_count = table_count[4:0];
		return r;
	endfunction

	function automatic void add_request(mode_t op, logic [31:0] k, logic [31:0] v, bit drain);
		request_t r;
		r.op = op;
		r.k = k;
		r.v = v;
		r.drain = drain;
		request_q.push_back(r);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= MODE_SET;
			key <= '0;
			value <= '0;
			words_sent <= 0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				table_expected_q.push_back(table_apply(mode_t'(mode), key, value));
				words_sent <= words_sent + 1;
			end
			if (in_valid && in_stall) begin
				in_valid <= 1'b1;
			end else if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (request_q.size() > 0 && (!request_q[0].drain ||
					(!in_valid && words_sent == results_seen))) begin
				next_request = request_q.pop_front();
				in_valid <= 1'b1;
				mode <= next_request.op;
				key <= next_request.k;
				value <= next_request.v;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			results_seen <= 0;
			hold_left <= 0;
			next_long_hold <= 80;
			stall_style <= 0;
			style_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen <= results_seen + 1;
				got_result.found = found;
				got_result.read_value = read_value;
				got_result.entry_count = entry_count;
				got_result.full_error = full_error;
				if (table_expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word, expected none, got %0h", $time,
						got_result);
				end else begin
					want_result = table_expected_q.pop_front();
					check_field("found", 32'(want_result.found), 32'(got_result.found));
					check_field("read_value", want_result.read_value, got_result.read_value);
					check_field("entry_count", 32'(want_result.entry_count),
						32'(got_result.entry_count));
					check_field("full_error", 32'(want_result.full_error),
						32'(got_result.full_error));
				end
			end
			if (style_left == 0) begin
				stall_style <= $urandom_range(0, 3);
				style_left <= $urandom_range(20, 80);
			end else begin
				style_left <= style_left - 1;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (results_seen >= next_long_hold) begin
				out_stall <= 1'b1;
				hold_left <= 250;
				next_long_hold <= next_long_hold + 230;
			end else begin
				case (stall_style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 3) != 0);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	initial begin
		logic [31:0] key_pool [POOL_SIZE];
		logic [31:0] k;
		mode_t op;
		int n;
		int i;
		int pick;
		int del_weight;

		add_request(MODE_GET, 32'h1234_5678, 32'hFFFF_FFFF, 1'b0);
		add_request(MODE_DELETE, 32'h1234_5678, 32'h0, 1'b0);
		add_request(MODE_SET, 32'h0, 32'h0, 1'b0);
		add_request(MODE_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_request(MODE_GET, 32'h0, 32'h0, 1'b0);
		add_request(MODE_SET, 32'h0, 32'hA5A5_A5A5, 1'b0);
		add_request(MODE_GET, 32'hFFFF_FFFF, 32'h5A5A_5A5A, 1'b0);
		add_request(MODE_DELETE, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0);
		for (i = 1; i <= 14; i++) begin
			add_request(MODE_SET, i, ~i, 1'b0);
		end
		add_request(MODE_SET, 32'h00C0_FFEE, 32'h1111_1111, 1'b0);
		add_request(MODE_SET, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 1'b0);
		add_request(MODE_DELETE, 32'h0, 32'h0, 1'b0);
		add_request(MODE_DELETE, 32'd14, 32'h0, 1'b0);
		add_request(MODE_GET, 32'd7, 32'h0, 1'b0);
		add_request(MODE_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		add_request(MODE_GET, 32'hFFFF_FFFF, 32'h0, 1'b0);

		del_weight = 25;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 90 == 0) begin
				for (i = 0; i < POOL_SIZE; i++) begin
					key_pool[i] = $urandom;
				end
				key_pool[0] = 32'h0;
				key_pool[1] = 32'hFFFF_FFFF;
				del_weight = (n % 180 == 0) ? 25 : 8;
			end
			k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				op = MODE_SET;
			end else if (pick < 98 - del_weight) begin
				op = MODE_GET;
			end else if (pick < 98) begin
				op = MODE_DELETE;
			end else begin
				op = MODE_CLEAR;
			end
			add_request(op, k, $urandom, n % 150 == 0);
		end
		total_words = request_q.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (words_sent != total_words || results_seen != words_sent) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
		if (table_expected_q.size() != 0) begin
			errors++;
			$display("%0t: result words still expected, expected 0, got %0d", $time,
				table_expected_q.size());
		end
		if (errors == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

	initial begin
		#(20_000_000);
		$display("tb: errors");
		$finish;
	end

endmodule

>>> linear_key_value_table_unit.f
rtl/lkvt_pkg.sv
rtl/lkvt_dp.sv
rtl/lkvt_ctrl.sv
rtl/linear_key_value_table_unit.sv
tb/sv/tb.sv
